[rtl/core/fbfl_pkg.sv]
// Shared types and constants of the fixed-size block free-list allocator.
// Holds the beat structs, operation and status codes and the sequencer states.
// Depends on nothing; every other file of the block imports it.
package fbfl_pkg;

  // Field widths, fixed by the interface.
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned INDEX_W    = 8;
  localparam int unsigned SIZE_W     = 13;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PROD_W     = 21;
  localparam int unsigned REM_W      = 14;
  localparam int unsigned CFG_IDX_W  = 1;

  // Step counts of the shared shift/add unit.
  localparam int unsigned DIV_STEPS  = 20;
  localparam int unsigned MUL_STEPS  = 8;
  localparam int unsigned STEP_CNT_W = 5;

  localparam logic [OFFSET_W-1:0] OFFSET_MAX = 20'hFFFFF;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = 8'hFF;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_EMPTY      = 2'd1,
    STATUS_BAD_OFFSET = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE  = 1'b0,
    CFG_BLOCK_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE,
    S_RESP
  } state_e;

  typedef enum logic {
    MODE_MUL,
    MODE_DIV
  } arith_mode_e;

  typedef struct packed {
    logic [1:0]          operation;
    logic [OFFSET_W-1:0] release_offset;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [INDEX_W-1:0]  block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [COUNT_W-1:0]  blocks_free;
  } out_t;

  // Request to the shared unit: dividend or multiplier in operand_a,
  // divisor or multiplicand in operand_b.
  typedef struct packed {
    logic                start;
    arith_mode_e         mode;
    logic [OFFSET_W-1:0] operand_a;
    logic [SIZE_W-1:0]   operand_b;
  } arith_req_t;

  typedef struct packed {
    logic                done;
    logic [OFFSET_W-1:0] quotient;
    logic [REM_W-1:0]    remainder;
    logic [PROD_W-1:0]   product;
  } arith_rsp_t;

endpackage

[rtl/core/fbfl_arith_unit.sv]
// Shared shift/add unit: restoring division and shift-add multiplication.
// One 22-bit adder serves both, one bit per cycle under a step counter.
// Depends on fbfl_pkg.
module fbfl_arith_unit
  import fbfl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  arith_req_t req_i,
  output arith_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  arith_mode_e           mode_q;
  logic [PROD_W-1:0]     acc_q, acc_d;
  logic [OFFSET_W-1:0]   sh_q, sh_d;
  logic [SIZE_W-1:0]     opb_q;

  logic [REM_W-1:0]      trial;
  logic [PROD_W-1:0]     add_a, add_b;
  logic                  sub;
  logic [PROD_W:0]       sum;
  logic                  no_borrow;
  logic                  last_step;

  // Operand selection for the one shared adder.
  always_comb begin
    trial = {acc_q[REM_W-2:0], sh_q[OFFSET_W-1]};
    if (mode_q == MODE_DIV) begin
      add_a = {{(PROD_W-REM_W){1'b0}}, trial};
      add_b = {{(PROD_W-SIZE_W){1'b0}}, opb_q};
      sub   = 1'b1;
    end else begin
      add_a = {acc_q[PROD_W-2:0], 1'b0};
      add_b = sh_q[OFFSET_W-1] ? {{(PROD_W-SIZE_W){1'b0}}, opb_q} : '0;
      sub   = 1'b0;
    end
    sum = {1'b0, add_a} + {1'b0, (sub ? ~add_b : add_b)} + {{PROD_W{1'b0}}, sub};
    no_borrow = sum[PROD_W];
  end

  // Next remainder or partial product, and the shifted operand.
  always_comb begin
    if (mode_q == MODE_DIV) begin
      acc_d = no_borrow ? {{(PROD_W-REM_W){1'b0}}, sum[REM_W-1:0]}
                        : {{(PROD_W-REM_W){1'b0}}, trial};
      sh_d  = {sh_q[OFFSET_W-2:0], no_borrow};
    end else begin
      acc_d = sum[PROD_W-1:0];
      sh_d  = {sh_q[OFFSET_W-2:0], 1'b0};
    end
    last_step = (mode_q == MODE_DIV) ? (cnt_q == STEP_CNT_W'(DIV_STEPS - 1))
                                     : (cnt_q == STEP_CNT_W'(MUL_STEPS - 1));
  end

  // Step counter and completion flag.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + STEP_CNT_W'(1);
      if (last_step) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers; loaded on start, stepped while busy.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mode_q <= req_i.mode;
      acc_q  <= '0;
      sh_q   <= (req_i.mode == MODE_DIV) ? req_i.operand_a
                : {req_i.operand_a[INDEX_W-1:0], {(OFFSET_W-INDEX_W){1'b0}}};
      opb_q  <= req_i.operand_b;
    end else if (busy_q) begin
      acc_q <= acc_d;
      sh_q  <= sh_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = sh_q;
  assign rsp_o.remainder = acc_q[REM_W-1:0];
  assign rsp_o.product   = acc_q;

endmodule

[rtl/core/fbfl_link_store.sv]
// Next-free link memory with one valid bit per entry.
// An entry never written since the last clear reads as its own index plus one.
// Depends on fbfl_pkg.
module fbfl_link_store
  import fbfl_pkg::*;
#(
  parameter int unsigned DEPTH = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               clear_i,
  input  logic               we_i,
  input  logic [INDEX_W-1:0] waddr_i,
  input  logic [INDEX_W-1:0] wdata_i,
  input  logic [INDEX_W-1:0] raddr_i,
  output logic [INDEX_W-1:0] rdata_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [INDEX_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [INDEX_W-1:0] rd_data_q;
  logic [INDEX_W-1:0] rd_addr_q;
  logic               rd_vld_q;

  // Memory write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i[AW-1:0]] <= wdata_i;
    end
    rd_data_q <= mem_q[raddr_i[AW-1:0]];
    rd_vld_q  <= vld_q[raddr_i[AW-1:0]];
    rd_addr_q <= raddr_i;
  end

  // Valid bits: cleared at once by reset or by a rebuild of the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i[AW-1:0]] <= 1'b1;
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : rd_addr_q + INDEX_W'(1);

endmodule

[rtl/core/fixed_block_free_list_allocator_core.sv]
// Top level of the fixed-size block free-list allocator.
// Sequencer, configuration registers and output register; uses fbfl_pkg,
// fbfl_arith_unit and fbfl_link_store.
//
//   channel  direction  handshake          beat
//   in       input      in_valid/in_stall  in_t  (operation, release_offset)
//   out      output     out_valid/out_stall out_t (status, index, offset, free)
//   cfg      input      cfg_valid/cfg_ready index and data, always ready
//
// Free runs the 20 steps of the bit-serial divider, then commits the link
// and loads the output register. Allocate runs the 8 steps of the shift-add
// multiplier on the same unit. Reinitialize, allocate when empty and the
// unused code go straight to the output register.
// Reset and reinitialize clear all link valid bits at once; no sweep.
// A stalled output holds its beat while the next item is already taken in.
module fixed_block_free_list_allocator_core
  import fbfl_pkg::*;
#(
  parameter int unsigned MAX_BLOCKS = 255
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [SIZE_W-1:0]    cfg_data_i
);

  localparam logic [INDEX_W-1:0] MAX_IDX = INDEX_W'(MAX_BLOCKS);

  state_e              state_q, state_d;
  logic [SIZE_W-1:0]   block_size_q;
  logic [COUNT_W-1:0]  block_count_q;
  logic [INDEX_W-1:0]  head_q, head_d;
  logic [COUNT_W-1:0]  free_q, free_d;
  in_t                 in_q, in_d;
  out_t                res_q, res_d;
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;

  logic [SIZE_W-1:0]   eff_size;
  logic [COUNT_W-1:0]  eff_count;
  logic                alloc_ok;
  logic                in_accept;
  logic                free_bad;
  logic [INDEX_W-1:0]  q_idx;
  logic [COUNT_W-1:0]  count_inc;

  arith_req_t          arith_req;
  arith_rsp_t          arith_rsp;

  logic                link_clear;
  logic                link_we;
  logic [INDEX_W-1:0]  link_rdata;

  fbfl_arith_unit u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (arith_req),
    .rsp_o  (arith_rsp)
  );

  fbfl_link_store #(
    .DEPTH (MAX_BLOCKS)
  ) u_links (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (link_clear),
    .we_i    (link_we),
    .waddr_i (q_idx),
    .wdata_i (head_q),
    .raddr_i (head_q),
    .rdata_o (link_rdata)
  );

  // Effective configuration values.
  assign eff_size  = (block_size_q == '0) ? SIZE_W'(1) : block_size_q;
  assign eff_count = (block_count_q > MAX_IDX) ? MAX_IDX : block_count_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && (state_q == S_IDLE);
  assign alloc_ok    = (free_q != '0) && (head_q < MAX_IDX);
  assign cfg_ready_o = 1'b1;

  // Checks on the quotient and remainder of a free.
  assign q_idx     = arith_rsp.quotient[INDEX_W-1:0];
  assign free_bad  = (arith_rsp.remainder != '0) ||
                     (arith_rsp.quotient >= {{(OFFSET_W-COUNT_W){1'b0}}, eff_count});
  assign count_inc = (free_q == COUNT_MAX) ? free_q : free_q + COUNT_W'(1);

  // Sequencer: next state, list updates and result.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    free_d      = free_q;
    in_d        = in_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    link_clear  = 1'b0;
    link_we     = 1'b0;
    arith_req.start     = 1'b0;
    arith_req.mode      = MODE_MUL;
    arith_req.operand_a = {{(OFFSET_W-INDEX_W){1'b0}}, head_q};
    arith_req.operand_b = eff_size;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_data_i;
          res_d = '{status: STATUS_OK, block_index: '0, byte_offset: '0,
                    blocks_free: free_q};
          case (op_e'(in_data_i.operation))
            OP_ALLOC: begin
              if (alloc_ok) begin
                arith_req.start = 1'b1;
                state_d         = S_ALLOC;
              end else begin
                res_d.status = STATUS_EMPTY;
                state_d      = S_RESP;
              end
            end
            OP_FREE: begin
              arith_req.start     = 1'b1;
              arith_req.mode      = MODE_DIV;
              arith_req.operand_a = in_data_i.release_offset;
              state_d             = S_FREE;
            end
            OP_REINIT: begin
              link_clear        = 1'b1;
              head_d            = '0;
              free_d            = eff_count;
              res_d.blocks_free = eff_count;
              state_d           = S_RESP;
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_ALLOC: begin
        if (arith_rsp.done) begin
          head_d            = link_rdata;
          free_d            = free_q - COUNT_W'(1);
          res_d.block_index = head_q;
          res_d.byte_offset = arith_rsp.product[PROD_W-1] ? OFFSET_MAX
                              : arith_rsp.product[OFFSET_W-1:0];
          res_d.blocks_free = free_q - COUNT_W'(1);
          state_d           = S_RESP;
        end
      end
      S_FREE: begin
        if (arith_rsp.done) begin
          if (free_bad) begin
            res_d.status = STATUS_BAD_OFFSET;
          end else begin
            link_we           = 1'b1;
            head_d            = q_idx;
            free_d            = count_inc;
            res_d.block_index = q_idx;
            res_d.byte_offset = in_q.release_offset;
            res_d.blocks_free = count_inc;
          end
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and list head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      free_q      <= MAX_IDX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= SIZE_W'(1);
      block_count_q <= COUNT_MAX;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i;
        CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  // The shared unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_rsp.done |-> (state_q == S_ALLOC || state_q == S_FREE))
    else $error("arithmetic unit finished outside a waiting state");

  // A rebuild resets the head and loads the effective count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.operation == OP_REINIT)
    |=> (head_q == '0 && free_q == $past(eff_count)))
    else $error("rebuild left head or free count wrong");

  // A completed allocation takes exactly one block off the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && arith_rsp.done) |=> (free_q == $past(free_q) - COUNT_W'(1)))
    else $error("allocation did not decrement the free count");
`endif

endmodule

[tb/sv/fixed_block_free_list_allocator_core_tb.sv]
// Self-checking testbench for fixed_block_free_list_allocator_core.
// Checks every result beat against a cycle-free allocator predictor held in this file.
// Depends on fbfl_pkg and the allocator core RTL only.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_core_tb;
  import fbfl_pkg::*;

  localparam int unsigned MAX_BLOCKS = 255;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 30;

  // Block ports.
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [SIZE_W-1:0]    cfg_data_i  = '0;

  // Traffic shaping.
  int unsigned gap_pct     = 10;
  int unsigned stall_pct   = 10;
  logic        hold_active = 1'b0;

  // Allocator state as the testbench predicts it.
  logic [SIZE_W-1:0]  cfg_size;
  logic [COUNT_W-1:0] cfg_count;
  logic [INDEX_W-1:0] chain_next [MAX_BLOCKS];
  logic [INDEX_W-1:0] head_blk;
  logic [COUNT_W-1:0] free_blocks;
  logic [INDEX_W-1:0] held_blocks [$];

  // Result beats still owed by the block, oldest first.
  out_t awaited_results [$];

  int unsigned fail_cnt     = 0;
  int unsigned results_seen = 0;
  int unsigned op_seen [4];
  int unsigned status_seen [4];

  fixed_block_free_list_allocator_core #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver stalls at random, or solidly while a hold-off is in force.
  always @(posedge clk_i) begin
    out_stall_i <= hold_active || ($urandom_range(99) < stall_pct);
  end

  // Rebuilds the free chain 0 -> 1 -> 2 ... and resets the free count.
  function automatic void rebuild_chain();
    int unsigned i;
    for (i = 0; i < MAX_BLOCKS; i++) begin
      chain_next[i] = INDEX_W'(i + 1);
    end
    head_blk    = '0;
    // The count register is 8 bits wide, so it never exceeds MAX_BLOCKS.
    free_blocks = cfg_count;
    held_blocks.delete();
  endfunction

  // Applies one request to the predicted state and returns the beat it yields.
  function automatic out_t predict_result(input in_t item);
    out_t        res;
    int unsigned bsz;
    int unsigned quo;
    int unsigned prod;
    int          k;
    res = '0;
    bsz = (cfg_size == '0) ? 1 : cfg_size;
    case (item.operation)
      OP_ALLOC: begin
        if (free_blocks == '0 || head_blk >= MAX_BLOCKS) begin
          res.status = STATUS_EMPTY;
        end else begin
          prod = head_blk * bsz;
          res.block_index = head_blk;
          res.byte_offset = (prod > OFFSET_MAX) ? OFFSET_MAX : prod[OFFSET_W-1:0];
          held_blocks.push_back(head_blk);
          head_blk    = chain_next[head_blk];
          free_blocks = free_blocks - 1'b1;
        end
      end
      OP_FREE: begin
        quo = item.release_offset / bsz;
        if ((item.release_offset % bsz) != 0 || quo >= cfg_count) begin
          res.status = STATUS_BAD_OFFSET;
        end else begin
          res.block_index = quo[INDEX_W-1:0];
          res.byte_offset = item.release_offset;
          chain_next[quo] = head_blk;
          head_blk = quo[INDEX_W-1:0];
          if (free_blocks != COUNT_MAX) begin
            free_blocks = free_blocks + 1'b1;
          end
          for (k = held_blocks.size() - 1; k >= 0; k--) begin
            if (held_blocks[k] == quo) begin
              held_blocks.delete(k);
              break;
            end
          end
        end
      end
      OP_REINIT: begin
        rebuild_chain();
      end
      default: begin
      end
    endcase
    res.blocks_free = free_blocks;
    return res;
  endfunction

  // Draws one request, mostly frees of blocks handed out earlier and allocations.
  function automatic in_t random_request();
    in_t         it;
    int unsigned bsz;
    int unsigned cnt;
    int unsigned roll;
    int unsigned pick;
    bsz = (cfg_size == '0) ? 1 : cfg_size;
    cnt = cfg_count;
    roll = $urandom_range(99);
    it.operation = OP_ALLOC;
    it.release_offset = OFFSET_W'($urandom_range(0, OFFSET_MAX));
    if (roll < 42) begin
      it.operation = OP_ALLOC;
    end else if (roll < 78) begin
      if (held_blocks.size() != 0) begin
        pick = held_blocks[$urandom_range(held_blocks.size() - 1)];
        it.operation = OP_FREE;
        it.release_offset = OFFSET_W'(pick * bsz);
      end
    end else if (roll < 84) begin
      // Misaligned offset.
      it.operation = OP_FREE;
      it.release_offset = OFFSET_W'($urandom_range(0, cnt) * bsz +
                                    ((bsz > 1) ? $urandom_range(1, bsz - 1) : 0));
    end else if (roll < 88) begin
      // Aligned, but past the configured blocks.
      it.operation = OP_FREE;
      it.release_offset = OFFSET_W'((cnt + $urandom_range(0, 3)) * bsz);
    end else if (roll < 91) begin
      // Any block in range, free or not, so double frees happen.
      it.operation = OP_FREE;
      it.release_offset = OFFSET_W'($urandom_range(0, (cnt == 0) ? 0 : cnt - 1) * bsz);
    end else if (roll < 94) begin
      it.operation = OP_FREE;
    end else if (roll < 97) begin
      it.operation = OP_REINIT;
    end else begin
      it.operation = OP_UNUSED;
    end
    return it;
  endfunction

  // Offers one beat on the input channel and records its expected result.
  task automatic send_request(input logic [1:0] op, input logic [OFFSET_W-1:0] offset);
    in_t  item;
    out_t want;
    item.operation      = op;
    item.release_offset = offset;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    want = predict_result(item);
    awaited_results.push_back(want);
    op_seen[op]++;
    status_seen[want.status]++;
  endtask

  // Stops offering beats and waits until every expected result has come back.
  task automatic await_idle();
    in_valid_i <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes both registers while the block is idle.
  task automatic configure(input logic [SIZE_W-1:0] size_val,
                           input logic [SIZE_W-1:0] count_val);
    await_idle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_BLOCK_SIZE;
    cfg_data_i  <= size_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_size = size_val;
    cfg_index_i <= CFG_BLOCK_COUNT;
    cfg_data_i  <= count_val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_count = count_val[COUNT_W-1:0];
    cfg_valid_i <= 1'b0;
  endtask

  // Result checker: every accepted beat is matched with the oldest expectation.
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) begin
          $display("Unexpected result beat: status %0d index %0d offset 0x%05h free %0d",
                   out_data_o.status, out_data_o.block_index, out_data_o.byte_offset,
                   out_data_o.blocks_free);
        end
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.status !== want.status || out_data_o.block_index !== want.block_index ||
            out_data_o.byte_offset !== want.byte_offset ||
            out_data_o.blocks_free !== want.blocks_free) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("Result %0d wrong: expected %0d/%0d/0x%05h/%0d got %0d/%0d/0x%05h/%0d",
                     results_seen, want.status, want.block_index, want.byte_offset,
                     want.blocks_free, out_data_o.status, out_data_o.block_index,
                     out_data_o.byte_offset, out_data_o.blocks_free);
          end
        end
      end
    end
  end

  // Reset settings: allocate, good and bad frees, a double free, the unused code, a rebuild.
  task automatic test_reset_state();
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, OFFSET_MAX);
    send_request(OP_FREE, 20'd0);
    send_request(OP_FREE, 20'd255);
    send_request(OP_FREE, 20'd254);
    send_request(OP_FREE, OFFSET_MAX);
    send_request(OP_UNUSED, OFFSET_MAX);
    send_request(OP_REINIT, '0);
  endtask

  // One 4096-byte block: empty allocate, misaligned and out-of-range frees, double free.
  task automatic test_single_large_block();
    configure(13'd4096, 13'd1);
    send_request(OP_REINIT, OFFSET_MAX);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 20'd4095);
    send_request(OP_FREE, 20'd4096);
    send_request(OP_FREE, 20'd0);
    send_request(OP_FREE, 20'd0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_ALLOC, '0);
  endtask

  // Zero block size acts as one; zero block count leaves nothing to hand out.
  // The upper bits of the count write must be dropped.
  task automatic test_zero_settings();
    configure('0, 13'h1F00);
    send_request(OP_REINIT, '0);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, 20'd0);
  endtask

  // An allocated offset beyond the 20-bit range saturates.
  task automatic test_offset_clamp();
    configure(13'd1, 13'd255);
    send_request(OP_REINIT, '0);
    send_request(OP_FREE, 20'd200);
    configure(13'h1FFF, 13'd255);
    send_request(OP_ALLOC, '0);
    send_request(OP_FREE, OFFSET_MAX);
  endtask

  // Receiver holds off for a long stretch while requests keep coming.
  task automatic test_output_backpressure();
    configure(13'd16, 13'd255);
    send_request(OP_REINIT, '0);
    fork
      begin
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active <= 1'b0;
      end
      repeat (30) send_request(($urandom_range(3) == 0) ? OP_FREE : OP_ALLOC,
                               OFFSET_W'($urandom_range(0, 40) * 16));
    join
  endtask

  // Random traffic over a series of settings, the extremes first.
  task automatic test_random_traffic(input int unsigned gap, input int unsigned stall,
                                     input int unsigned target);
    int unsigned       sent;
    int unsigned       phase_no;
    int unsigned       roll;
    logic [SIZE_W-1:0] size_val;
    logic [SIZE_W-1:0] count_val;
    in_t               it;
    sent = 0;
    phase_no = 0;
    gap_pct = gap;
    stall_pct = stall;
    while (sent < target) begin
      case (phase_no)
        0: configure(13'd1, 13'd255);
        1: configure(13'd4096, 13'd255);
        2: configure(13'd4096, 13'd1);
        default: begin
          roll = $urandom_range(9);
          if (roll < 5) size_val = SIZE_W'($urandom_range(1, 64));
          else if (roll < 8) size_val = SIZE_W'($urandom_range(1, 4096));
          else if (roll == 8) size_val = SIZE_W'($urandom_range(4097, 8191));
          else size_val = SIZE_W'($urandom_range(0, 8191));
          roll = $urandom_range(9);
          count_val[SIZE_W-1:COUNT_W] = (SIZE_W-COUNT_W)'($urandom_range(0, 31));
          if (roll < 6) count_val[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 16));
          else if (roll < 9) count_val[COUNT_W-1:0] = COUNT_W'($urandom_range(1, 255));
          else count_val[COUNT_W-1:0] = ($urandom_range(1) == 0) ? 8'd0 : 8'd255;
          configure(size_val, count_val);
        end
      endcase
      // Now and then the list is left as it was, so settings change under it.
      if ($urandom_range(9) != 0) begin
        send_request(OP_REINIT, OFFSET_W'($urandom_range(0, OFFSET_MAX)));
        sent++;
      end
      repeat ($urandom_range(20, 70)) begin
        it = random_request();
        send_request(it.operation, it.release_offset);
        if (it.operation != OP_UNUSED) sent++;
      end
      phase_no++;
    end
  endtask

  initial begin
    cfg_size  = 13'd1;
    cfg_count = 8'd255;
    rebuild_chain();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_single_large_block();
    test_zero_settings();
    test_offset_clamp();
    test_output_backpressure();
    test_random_traffic(32, 60, 330);
    test_random_traffic(60, 32, 330);
    test_random_traffic(0, 0, 340);
    await_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d allocate, %0d free, %0d reinitialise and %0d unused-code requests;",
             op_seen[OP_ALLOC], op_seen[OP_FREE], op_seen[OP_REINIT], op_seen[OP_UNUSED]);
    $display("checked %0d results, %0d empty pools and %0d rejected offsets among them.",
             results_seen, status_seen[STATUS_EMPTY], status_seen[STATUS_BAD_OFFSET]);
    if (fail_cnt == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(5_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_arith_unit.sv
rtl/core/fbfl_link_store.sv
rtl/core/fixed_block_free_list_allocator_core.sv
tb/sv/fixed_block_free_list_allocator_core_tb.sv
